### hw/rtl/octilinear_route_obstacle_check_top_defines.svh
// ----------------------------------------------------------------------------
// octilinear route obstacle check assertion macros
// concurrent check helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef OCTILINEAR_ROUTE_OBSTACLE_CHECK_TOP_DEFINES_SVH
`define OCTILINEAR_ROUTE_OBSTACLE_CHECK_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define OROC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define OROC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OROC_ASSERT(lbl, prop, msg)
`define OROC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/oroc_pkg.sv
// ----------------------------------------------------------------------------
// oroc_pkg
// shared types and constants of the octilinear route obstacle check
// ----------------------------------------------------------------------------
`default_nettype none
package oroc_pkg;
	localparam int MAX_OBSTACLES = 64;
	localparam int COORD_BITS = 16;
	localparam int AW = $clog2(MAX_OBSTACLES);
	localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
	localparam int CW = COORD_BITS + 3;
	localparam int CFG_W = 7;
	localparam int RECT_W = 4 * COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [CW-1:0] cw_t;
	typedef logic [AW-1:0] addr_t;

	typedef struct packed {
		coord_t lx;
		coord_t by;
		coord_t rx;
		coord_t ty;
	} rect_t;

	typedef struct packed {
		logic hok;
		logic vok;
		logic dok;
		logic up;
		coord_t hpos;
		coord_t hlo;
		coord_t hhi;
		coord_t vpos;
		coord_t vlo;
		coord_t vhi;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		coord_t dly;
		coord_t dhy;
		coord_t l;
		coord_t r;
		coord_t b;
		coord_t t;
	} route_t;

	typedef struct packed {
		logic vld;
		logic fin;
		addr_t slot;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic hit;
	} res_t;

	function automatic cw_t ext(input coord_t v);
		ext = $signed({{(CW-COORD_BITS){1'b0}}, v});
	endfunction
endpackage
`default_nettype wire

### hw/rtl/oroc_mem.sv
// ----------------------------------------------------------------------------
// oroc_mem
// obstacle rectangle table, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module oroc_mem (
	input wire logic clk,
	input wire logic wr_en,
	input wire oroc_pkg::addr_t wr_addr,
	input wire oroc_pkg::rect_t wr_data,
	input wire logic rd_en,
	input wire oroc_pkg::addr_t rd_addr,
	output oroc_pkg::rect_t rd_data
);
	import oroc_pkg::*;

	rect_t mem [MAX_OBSTACLES];
	rect_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

### hw/rtl/oroc_eval.sv
// ----------------------------------------------------------------------------
// oroc_eval
// two-stage obstacle test against the current route
// ----------------------------------------------------------------------------
`default_nettype none
module oroc_eval (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire oroc_pkg::route_t route,
	input wire oroc_pkg::rect_t rect,
	input wire oroc_pkg::tok_t tok,
	output oroc_pkg::res_t res
);
	import oroc_pkg::*;

	// stage 1 signals
	logic reject, hhit, vhit, ins;
	cw_t q, c0, c1, c2, c3;

	tok_t tok_s1;
	rect_t rect_s1;
	logic reject_s1, hhit_s1, vhit_s1, ins_s1;
	cw_t c_s1 [4];

	// stage 2 signals
	logic [3:0] m;
	cw_t px [4];
	cw_t py [4];
	logic [1:0] ia, ib;
	logic found_a, found_b;
	logic [2:0] cnt;
	logic dblk, hit;
	res_t res_s2;

	always_comb begin
		reject = (rect.lx >= route.r) || (rect.by >= route.t) ||
			(rect.rx <= route.l) || (rect.ty <= route.b);
		hhit = route.hok && !((route.hpos <= rect.by) || (route.hpos >= rect.ty) ||
			(route.hhi <= rect.lx) || (route.hlo >= rect.rx));
		vhit = route.vok && !((route.vpos <= rect.lx) || (route.vpos >= rect.rx) ||
			(route.vhi <= rect.by) || (route.vlo >= rect.ty));
		ins = (route.sx > rect.lx && route.sx < rect.rx &&
			route.sy > rect.by && route.sy < rect.ty) ||
			(route.ex > rect.lx && route.ex < rect.rx &&
			route.ey > rect.by && route.ey < rect.ty);
		q = route.up ? ext(route.sy) - ext(route.sx) : ext(route.sy) + ext(route.sx);
		c0 = route.up ? ext(rect.by) - q : q - ext(rect.by);
		c1 = route.up ? ext(rect.ty) - q : q - ext(rect.ty);
		c2 = route.up ? ext(rect.lx) + q : q - ext(rect.lx);
		c3 = route.up ? ext(rect.rx) + q : q - ext(rect.rx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (en) begin
			tok_s1 <= tok;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rect_s1 <= rect;
			reject_s1 <= reject;
			hhit_s1 <= hhit;
			vhit_s1 <= vhit;
			ins_s1 <= ins;
			c_s1[0] <= c0;
			c_s1[1] <= c1;
			c_s1[2] <= c2;
			c_s1[3] <= c3;
		end
	end

	always_comb begin
		m[0] = c_s1[0] >= ext(rect_s1.lx) && c_s1[0] <= ext(rect_s1.rx) &&
			c_s1[0] >= ext(route.sx) && c_s1[0] <= ext(route.ex);
		m[1] = c_s1[1] >= ext(rect_s1.lx) && c_s1[1] <= ext(rect_s1.rx) &&
			c_s1[1] >= ext(route.sx) && c_s1[1] <= ext(route.ex);
		m[2] = c_s1[2] >= ext(rect_s1.by) && c_s1[2] <= ext(rect_s1.ty) &&
			c_s1[2] >= ext(route.dly) && c_s1[2] <= ext(route.dhy);
		m[3] = c_s1[3] >= ext(rect_s1.by) && c_s1[3] <= ext(rect_s1.ty) &&
			c_s1[3] >= ext(route.dly) && c_s1[3] <= ext(route.dhy);
		px[0] = c_s1[0];
		py[0] = ext(rect_s1.by);
		px[1] = c_s1[1];
		py[1] = ext(rect_s1.ty);
		px[2] = ext(rect_s1.lx);
		py[2] = c_s1[2];
		px[3] = ext(rect_s1.rx);
		py[3] = c_s1[3];
		ia = '0;
		ib = '0;
		found_a = 1'b0;
		found_b = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (m[i] && found_a && !found_b) begin
				ib = 2'(i);
				found_b = 1'b1;
			end
			if (m[i] && !found_a) begin
				ia = 2'(i);
				found_a = 1'b1;
			end
		end
		cnt = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
		dblk = ins_s1 || (cnt >= 3'd3) ||
			(cnt == 3'd2 && !(px[ia] == px[ib] && py[ia] == py[ib]));
		hit = !reject_s1 && (hhit_s1 || vhit_s1 || (route.dok && dblk));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (en) begin
			res_s2.tok <= tok_s1;
			res_s2.hit <= hit && tok_s1.vld && !tok_s1.fin;
		end
	end

	assign res = res_s2;
endmodule
`default_nettype wire

### hw/rtl/octilinear_route_obstacle_check_top.sv
// load: a load beat is written at its accepting edge; a query scans the first
// min(active_obstacles, 64) table slots and ends with a final result beat
// throughput: one obstacle per cycle through the table read port while the output
// is not stalled; a new beat is accepted only once the query's scan is back in idle
// reset: arst_n clears control state and the active count; the table is
// undefined until loaded
// ----------------------------------------------------------------------------
// octilinear_route_obstacle_check_top
// obstacle table with route setup, scan sequencer and result buffering
// ----------------------------------------------------------------------------
`default_nettype none
`include "octilinear_route_obstacle_check_top_defines.svh"
module octilinear_route_obstacle_check_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [oroc_pkg::CFG_W-1:0] cfg_wr_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// slot, obs_left, obs_bottom, obs_right, obs_top, src_x, src_y, dst_x, dst_y,
	// route_shape
	input wire logic [135:0] s_tdata,
	// kind
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// blocker_slot
	output logic [7:0] m_tdata,
	// hit_valid
	output logic m_tuser,
	output logic m_tlast
);
	import oroc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_SCAN, ST_DRAIN} state_t;

	state_t state_q;
	logic [CFG_W-1:0] active_q;
	logic [CNT_W-1:0] n_q, k_q;
	coord_t x1_q, y1_q, x2_q, y2_q;
	logic [1:0] shape_q;
	route_t route_q, rb;
	tok_t t0_q, t1_q;
	rect_t rdata;
	res_t res;
	logic adv, acc, pend_vld_q, emit;
	addr_t pend_slot_q;
	logic out_vld_q, out_hit_q, out_last_q;
	addr_t out_slot_q;
	rect_t wr_rect;

	// route build locals
	coord_t fx, fy, ax, ay, bx, by;
	logic swp, mm;

	assign adv = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign emit = adv && ((res.tok.vld && res.tok.fin) || (res.hit && pend_vld_q));
	assign wr_rect = '{lx: s_tdata[21:6], by: s_tdata[37:22],
		rx: s_tdata[53:38], ty: s_tdata[69:54]};

	oroc_mem u_mem (
		.clk(clk),
		.wr_en(acc && !s_tuser),
		.wr_addr(s_tdata[AW-1:0]),
		.wr_data(wr_rect),
		.rd_en(adv),
		.rd_addr(t0_q.slot),
		.rd_data(rdata)
	);

	oroc_eval u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.route(route_q),
		.rect(rdata),
		.tok(t1_q),
		.res(res)
	);

	always_comb begin
		fx = (x1_q > x2_q) ? x1_q - x2_q : x2_q - x1_q;
		fy = (y1_q > y2_q) ? y1_q - y2_q : y2_q - y1_q;
		swp = x1_q > x2_q;
		ax = swp ? x2_q : x1_q;
		ay = swp ? y2_q : y1_q;
		bx = swp ? x1_q : x2_q;
		by = swp ? y1_q : y2_q;
		mm = shape_q[0] ^ swp;
		rb = '0;
		rb.l = ax;
		rb.r = bx;
		rb.b = (y1_q < y2_q) ? y1_q : y2_q;
		rb.t = (y1_q < y2_q) ? y2_q : y1_q;
		if (shape_q[1] || fx == '0 || fy == '0) begin
			rb.hok = 1'b1;
			rb.vok = 1'b1;
			rb.hlo = rb.l;
			rb.hhi = rb.r;
			rb.vlo = rb.b;
			rb.vhi = rb.t;
			rb.hpos = (shape_q == 2'd0 || shape_q == 2'd3) ? y1_q : y2_q;
			rb.vpos = (shape_q == 2'd0 || shape_q == 2'd2) ? x1_q : x2_q;
		end else begin
			rb.dok = 1'b1;
			rb.up = ay < by;
			if (fx > fy) begin
				rb.hok = 1'b1;
				if (!mm) begin
					rb.hpos = ay;
					rb.hlo = ax;
					rb.hhi = bx - fy;
					rb.sx = bx - fy;
					rb.sy = ay;
					rb.ex = bx;
					rb.ey = by;
				end else begin
					rb.hpos = by;
					rb.hlo = ax + fy;
					rb.hhi = bx;
					rb.sx = ax;
					rb.sy = ay;
					rb.ex = ax + fy;
					rb.ey = by;
				end
			end else begin
				rb.vok = 1'b1;
				rb.sx = ax;
				rb.ex = bx;
				if (!mm) begin
					rb.vpos = ax;
					rb.ey = by;
					if (rb.up) begin
						rb.sy = by - fx;
						rb.vlo = ay;
						rb.vhi = by - fx;
					end else begin
						rb.sy = by + fx;
						rb.vlo = by + fx;
						rb.vhi = ay;
					end
				end else begin
					rb.vpos = bx;
					rb.sy = ay;
					if (rb.up) begin
						rb.ey = ay + fx;
						rb.vlo = ay + fx;
						rb.vhi = by;
					end else begin
						rb.ey = ay - fx;
						rb.vlo = by;
						rb.vhi = ay - fx;
					end
				end
			end
			rb.dly = rb.up ? rb.sy : rb.ey;
			rb.dhy = rb.up ? rb.ey : rb.sy;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x1_q <= s_tdata[85:70];
			y1_q <= s_tdata[101:86];
			x2_q <= s_tdata[117:102];
			y2_q <= s_tdata[133:118];
			shape_q <= s_tdata[135:134];
		end
		if (state_q == ST_BUILD) begin
			route_q <= rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= '0;
			n_q <= '0;
			k_q <= '0;
			t0_q <= '0;
			t1_q <= '0;
			pend_vld_q <= 1'b0;
			pend_slot_q <= '0;
			out_vld_q <= 1'b0;
			out_hit_q <= 1'b0;
			out_last_q <= 1'b0;
			out_slot_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && s_tuser) begin
						state_q <= ST_BUILD;
						k_q <= '0;
						n_q <= (active_q > CFG_W'(MAX_OBSTACLES)) ?
							CNT_W'(MAX_OBSTACLES) : CNT_W'(active_q);
					end
				end
				ST_BUILD: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (adv) begin
						if (k_q < n_q) begin
							t0_q <= '{vld: 1'b1, fin: 1'b0, slot: k_q[AW-1:0]};
							k_q <= k_q + 1'b1;
						end else begin
							t0_q <= '{vld: 1'b1, fin: 1'b1, slot: '0};
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						t0_q <= '0;
						if (res.tok.vld && res.tok.fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv) begin
				t1_q <= t0_q;
				if (res.tok.vld && res.tok.fin) begin
					out_slot_q <= pend_vld_q ? pend_slot_q : '0;
					out_hit_q <= pend_vld_q;
					out_last_q <= 1'b1;
					pend_vld_q <= 1'b0;
				end else if (res.hit) begin
					if (pend_vld_q) begin
						out_slot_q <= pend_slot_q;
						out_hit_q <= 1'b1;
						out_last_q <= 1'b0;
					end
					pend_vld_q <= 1'b1;
					pend_slot_q <= res.tok.slot;
				end
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = 8'(out_slot_q);
	assign m_tuser = out_hit_q;
	assign m_tlast = out_last_q;

	`OROC_ASSERT(a_idle_no_pend, (s_tready |-> !pend_vld_q), "pending hit while idle")
	`OROC_ASSERT(a_fin_emits, ((adv && res.tok.vld && res.tok.fin) |=> (m_tvalid && m_tlast)), "query end without final beat")
	`OROC_ASSERT(a_nohit_last, ((m_tvalid && !m_tuser) |-> m_tlast), "no-hit beat not final")
	`OROC_ASSERT_ALWAYS(a_reset_idle, (!arst_n |=> !m_tvalid), "output valid after reset")
endmodule
`default_nettype wire
